@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the debug packet deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dpd_pkg.sv @@
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, character codes and the hex digit decoder of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

  // Framing and reply characters.
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'

  // Kind of a result transaction.
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // One result transaction as it leaves the parser.
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] value;
  } dpd_res_t;

  // Parser status seen by the top level.
  typedef struct packed {
    logic stage_full;
    logic verdict_load;
    logic idle;
  } dpd_stat_t;

  // Decoded hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes '0'-'9', 'a'-'f' and 'A'-'F'; anything else is not a digit.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ design/dpd_parser.sv @@
// ----------------------------------------------------------------------------
// dpd_parser
// Input register and framing state machine: sums the payload, checks the
// two checksum digits and produces payload or verdict transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_parser #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_byte,
  output logic                 in_stall,
  input  wire logic            room,
  output dpd_pkg::dpd_res_t    res,
  output dpd_pkg::dpd_stat_t   stat
);

  localparam int CntW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_DIG1 = 4'b0100,
    PH_DIG2 = 4'b1000
  } phase_t;

  logic            full_r, full_nxt;
  logic [7:0]      byte_r;
  logic            take, advance;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [3:0]      hi_r, hi_nxt;
  logic            derr_r, derr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;

  dpd_pkg::hex_t   hex;
  logic            good;

  // Input register: holds one byte until the output side has room.
  assign advance  = full_r && room;
  assign in_stall = full_r && !room;
  assign take     = in_valid && !in_stall;
  assign full_nxt = take ? 1'b1 : (advance ? 1'b0 : full_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  // Framing state machine, evaluated for the byte in the input register.
  assign hex  = dpd_pkg::hex_decode(byte_r);
  assign good = !derr_r && hex.ok && !ovf_r && ({hi_r, hex.val} == sum_r);

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    derr_nxt  = derr_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    res.valid = 1'b0;
    res.kind  = dpd_pkg::KIND_BYTE;
    res.value = byte_r;
    if (advance) begin
      case (phase_r)
        PH_IDLE: begin
          if (byte_r == dpd_pkg::CH_START) begin
            phase_nxt = PH_DATA;
            sum_nxt   = 8'd0;
            hi_nxt    = 4'd0;
            derr_nxt  = 1'b0;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        PH_DATA: begin
          if (byte_r == dpd_pkg::CH_START) begin
            // A new start restarts the packet.
            sum_nxt  = 8'd0;
            hi_nxt   = 4'd0;
            derr_nxt = 1'b0;
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
          end else if (byte_r == dpd_pkg::CH_HASH) begin
            phase_nxt = PH_DIG1;
          end else begin
            sum_nxt = sum_r + byte_r;
            if (cnt_r >= MaxCnt) begin
              ovf_nxt = 1'b1;
            end else begin
              cnt_nxt   = cnt_r + 1'b1;
              res.valid = 1'b1;
            end
          end
        end
        PH_DIG1: begin
          hi_nxt    = hex.ok ? hex.val : 4'd0;
          derr_nxt  = derr_r || !hex.ok;
          phase_nxt = PH_DIG2;
        end
        PH_DIG2: begin
          derr_nxt  = derr_r || !hex.ok;
          phase_nxt = PH_IDLE;
          res.valid = 1'b1;
          res.kind  = good ? dpd_pkg::KIND_ACCEPT : dpd_pkg::KIND_REJECT;
          res.value = good ? dpd_pkg::CH_ACK : dpd_pkg::CH_NACK;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= 8'd0;
      hi_r    <= 4'd0;
      derr_r  <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      derr_r  <= derr_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Status for the top level.
  assign stat.stage_full   = full_r;
  assign stat.verdict_load = advance && (phase_r == PH_DIG2);
  assign stat.idle         = (phase_r == PH_IDLE);

endmodule

`default_nettype wire

@@ design/dpd_out_reg.sv @@
// ----------------------------------------------------------------------------
// dpd_out_reg
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dpd_pkg::dpd_res_t res,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_item_kind,
  output logic [7:0]             out_item_value
);

  logic          valid_r, valid_nxt;
  dpd_pkg::kind_t kind_r;
  logic [7:0]    value_r;

  // The register can be loaded when empty or drained in this cycle.
  assign room = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (room) begin
      valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (room && res.valid) begin
      kind_r  <= res.kind;
      value_r <= res.value;
    end
  end

  assign out_valid      = valid_r;
  assign out_item_kind  = 2'(kind_r);
  assign out_item_value = value_r;

endmodule

`default_nettype wire

@@ design/debug_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// debug_packet_deframer_core
// Deframer for '$' payload '#' hh packets on a debug serial link.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the input register is free or can
// pass its byte on; in_stall holds the flow otherwise. Each byte is captured
// in an input register, runs through the framing state machine from there and
// lands in the result register, so a payload byte or verdict is offered on the
// result port after both registers. Bytes outside a packet, including
// '+' and '-' acknowledgements, are dropped. Payload bytes are passed on as
// they arrive (kind 0); after the second checksum digit one verdict follows,
// kind 1 with '+' on a good checksum or kind 2 with '-' on a mismatch, a
// non-hex digit or a payload longer than MAX_PAYLOAD bytes. On a reject the
// consumer discards the payload it has already received.
`default_nettype none

module debug_packet_deframer_core #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_item_kind,
  output logic [7:0]      out_item_value
);

`include "assert_macros.svh"

  dpd_pkg::dpd_res_t  res;
  dpd_pkg::dpd_stat_t stat;
  logic               room;
  logic               out_accept, out_reject;
  logic               ack_byte, nack_byte;

  // Framing logic behind the input register.
  dpd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .room     (room),
    .res      (res),
    .stat     (stat)
  );

  // Result register toward the consumer.
  dpd_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .room           (room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item_kind  (out_item_kind),
    .out_item_value (out_item_value)
  );

  // Verdict kinds and reply bytes seen on the result port.
  assign out_accept = out_valid && (out_item_kind == dpd_pkg::KIND_ACCEPT);
  assign out_reject = out_valid && (out_item_kind == dpd_pkg::KIND_REJECT);
  assign ack_byte   = (out_item_value == dpd_pkg::CH_ACK);
  assign nack_byte  = (out_item_value == dpd_pkg::CH_NACK);

  // The input side only stalls while a byte waits in the input register.
  `DPD_ASSERT_NOW(a_stall_needs_byte, clk, rst_n, in_stall, stat.stage_full, "stall without a held byte")

  // A verdict always returns the state machine to waiting for a start.
  `DPD_ASSERT_NEXT(a_verdict_idle, clk, rst_n, stat.verdict_load, stat.idle, "no idle after verdict")

  // An accept transaction always carries the '+' reply byte.
  `DPD_ASSERT_NOW(a_accept_ack, clk, rst_n, out_accept, ack_byte, "accept without ack byte")

  // A reject transaction always carries the '-' reply byte.
  `DPD_ASSERT_NOW(a_reject_nack, clk, rst_n, out_reject, nack_byte, "reject without nack byte")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debug packet deframer. A short table of byte
// transactions covers stray bytes, accept and reject verdicts, non-hex
// checksum digits and a restart inside the payload. Random packets follow,
// with noise between them. An in-bench model of the framing logic predicts
// every result transaction that a table row does not pin, and each one leaving
// the block is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD = 4096;
  localparam int N_DIRECTED = 23;

  // One result transaction of the deframer.
  typedef struct packed {
    dpd_pkg::kind_t kind;
    logic [7:0]     value;
  } deframed_t;

  // One row of the directed table; a pinned row carries its result.
  typedef struct packed {
    logic [7:0]     b;
    logic           pinned;
    dpd_pkg::kind_t kind;
    logic [7:0]     value;
  } step_row_t;

  // Framing phases of the in-bench model.
  typedef enum logic [1:0] {
    RX_HUNT,
    RX_BODY,
    RX_CSUM_HI,
    RX_CSUM_LO
  } rx_phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_item_kind;
  logic [7:0] out_item_value;

  // Pinned expectation, driven alongside the byte it belongs to.
  logic      row_pinned = 1'b0;
  deframed_t row_expect = '{dpd_pkg::KIND_BYTE, 8'h00};

  // State of the in-bench model.
  rx_phase_t   rx_phase = RX_HUNT;
  logic [7:0]  rx_sum = 8'h00;
  logic [3:0]  rx_hi = 4'h0;
  logic        rx_bad_digit = 1'b0;
  int          rx_count = 0;
  logic        rx_overflow = 1'b0;

  deframed_t deframed_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mode_items;

  // Stray bytes, a checksum mismatch, extreme payload bytes with a good
  // checksum, a '$' as checksum digit, and a restart inside the payload.
  step_row_t directed_rows [N_DIRECTED] = '{
    '{dpd_pkg::CH_ACK,   1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{dpd_pkg::CH_NACK,  1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h00,             1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{dpd_pkg::CH_START, 1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{dpd_pkg::CH_HASH,  1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h30,             1'b0, dpd_pkg::KIND_BYTE,   8'h00},  // '0'
    // '1': sum 0 against 0x01
    '{8'h31,             1'b1, dpd_pkg::KIND_REJECT, dpd_pkg::CH_NACK},
    '{dpd_pkg::CH_START, 1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'hFF,             1'b1, dpd_pkg::KIND_BYTE,   8'hFF},
    '{8'h00,             1'b1, dpd_pkg::KIND_BYTE,   8'h00},
    '{dpd_pkg::CH_HASH,  1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h66,             1'b0, dpd_pkg::KIND_BYTE,   8'h00},  // 'f'
    '{8'h46,             1'b1, dpd_pkg::KIND_ACCEPT, dpd_pkg::CH_ACK},  // 'F'
    '{dpd_pkg::CH_START, 1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{dpd_pkg::CH_HASH,  1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    // Not a hex digit.
    '{dpd_pkg::CH_START, 1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h39,             1'b1, dpd_pkg::KIND_REJECT, dpd_pkg::CH_NACK},  // '9'
    '{dpd_pkg::CH_START, 1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h41,             1'b1, dpd_pkg::KIND_BYTE,   8'h41},  // 'A'
    // Restarts the packet.
    '{dpd_pkg::CH_START, 1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{dpd_pkg::CH_HASH,  1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h30,             1'b0, dpd_pkg::KIND_BYTE,   8'h00},
    '{8'h30,             1'b1, dpd_pkg::KIND_ACCEPT, dpd_pkg::CH_ACK}
  };

  debug_packet_deframer_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item_kind  (out_item_kind),
    .out_item_value (out_item_value)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value of a hex digit, or -1 when the byte is not one.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // Hex digit for a nibble, in either case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // Clears the per-packet state when a '$' opens a packet.
  function automatic void restart_frame();
    rx_phase = RX_BODY;
    rx_sum = 8'h00;
    rx_hi = 4'h0;
    rx_bad_digit = 1'b0;
    rx_count = 0;
    rx_overflow = 1'b0;
  endfunction

  // Advances the model by one byte; returns 1 when a result is due.
  function automatic bit deframe_step(input logic [7:0] b, output deframed_t res);
    int  nib;
    bit  good;
    res = '{dpd_pkg::KIND_BYTE, b};
    case (rx_phase)
      RX_HUNT: begin
        if (b == dpd_pkg::CH_START) restart_frame();
        return 1'b0;
      end
      RX_BODY: begin
        if (b == dpd_pkg::CH_START) begin
          restart_frame();
          return 1'b0;
        end
        if (b == dpd_pkg::CH_HASH) begin
          rx_phase = RX_CSUM_HI;
          return 1'b0;
        end
        rx_sum = rx_sum + b;
        // Bytes beyond the limit still count in the sum but are not passed on.
        if (rx_count >= MAX_PAYLOAD) begin
          rx_overflow = 1'b1;
          return 1'b0;
        end
        rx_count++;
        return 1'b1;
      end
      RX_CSUM_HI: begin
        nib = hex_nibble(b);
        if (nib < 0) begin
          rx_bad_digit = 1'b1;
          rx_hi = 4'h0;
        end else begin
          rx_hi = 4'(nib);
        end
        rx_phase = RX_CSUM_LO;
        return 1'b0;
      end
      default: begin
        nib = hex_nibble(b);
        if (nib < 0) begin
          rx_bad_digit = 1'b1;
          nib = 0;
        end
        good = !rx_bad_digit && !rx_overflow && ({rx_hi, 4'(nib)} == rx_sum);
        rx_phase = RX_HUNT;
        if (good) res = deframed_t'{dpd_pkg::KIND_ACCEPT, dpd_pkg::CH_ACK};
        else res = deframed_t'{dpd_pkg::KIND_REJECT, dpd_pkg::CH_NACK};
        return 1'b1;
      end
    endcase
  endfunction

  // Prints one mismatch line, up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("tb: mismatch: %s", what);
  endtask

  // Offers one byte, after a random gap, and waits for its acceptance.
  task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                           input dpd_pkg::kind_t kind = dpd_pkg::KIND_BYTE,
                           input logic [7:0] value = 8'h00);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    row_pinned <= pinned;
    row_expect <= '{kind, value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random byte that is neither '$' nor '#'.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == dpd_pkg::CH_START || b == dpd_pkg::CH_HASH) b = 8'($urandom_range(255));
    return b;
  endfunction

  // Sends one packet with random payload; the checksum is usually right,
  // sometimes wrong and sometimes carries a non-hex digit.
  task automatic send_frame(input int len);
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] csum;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] bad;
    bit         upper;
    int         pick;
    int         i;
    sum = 8'h00;
    upper = 1'($urandom_range(1));
    pick = $urandom_range(99);
    // Now and then a truncated packet that the real one restarts.
    if ($urandom_range(9) == 0) begin
      send_byte(dpd_pkg::CH_START);
      repeat ($urandom_range(3)) send_byte(body_byte());
      mode_items += 4;
    end
    send_byte(dpd_pkg::CH_START);
    for (i = 0; i < len; i++) begin
      // Mostly clean payload; a stray marker breaks the packet now and then.
      b = (len < 100) ? 8'($urandom_range(255)) : body_byte();
      sum = sum + b;
      send_byte(b);
    end
    send_byte(dpd_pkg::CH_HASH);
    csum = sum;
    if (pick >= 70 && pick < 85) csum = sum + 8'($urandom_range(1, 255));
    hi = hex_char(csum[7:4], upper);
    lo = hex_char(csum[3:0], upper);
    if (pick >= 85) begin
      bad = 8'($urandom_range(255));
      while (hex_nibble(bad) >= 0) bad = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) bad = dpd_pkg::CH_START;
      if ($urandom_range(1) == 1) hi = bad;
      else lo = bad;
    end
    send_byte(hi);
    send_byte(lo);
    mode_items += len + 4;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
  endtask

  // Random packets with noise between them, until enough bytes are sent.
  task automatic run_random(input int target);
    int len;
    mode_items = 0;
    while (mode_items < target) begin
      // Stray bytes outside a packet, often acknowledgements.
      if ($urandom_range(99) < 40) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(3))
            0: send_byte(dpd_pkg::CH_ACK);
            1: send_byte(dpd_pkg::CH_NACK);
            default: send_byte(body_byte());
          endcase
        end
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      send_frame(len);
    end
  endtask

  // Receiver stalls at the rate of the current mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Predicts each accepted byte and checks each accepted result.
  always @(posedge clk) begin
    deframed_t predicted;
    deframed_t want;
    bit        due;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due = deframe_step(in_byte, predicted);
        if (row_pinned) deframed_q.push_back(row_expect);
        else if (due) deframed_q.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %02h",
                                    out_item_kind, out_item_value));
        end else begin
          want = deframed_q.pop_front();
          if (out_item_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_item_kind, want.kind));
          if (out_item_value !== want.value)
            report_mismatch($sformatf("value %02h, expected %02h",
                                      out_item_value, want.value));
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, sender idling 37 of 100, receiver 66 of 100.
    send_idle_pct = 37;
    recv_stall_pct = 66;
    for (i = 0; i < N_DIRECTED; i++) begin
      send_byte(directed_rows[i].b, directed_rows[i].pinned,
                directed_rows[i].kind, directed_rows[i].value);
    end
    run_random(120);
    wait_drained();

    // Sides swapped.
    send_idle_pct = 66;
    recv_stall_pct = 37;
    run_random(120);
    wait_drained();

    // No idling at either side.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(120);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && deframed_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+design
design/dpd_pkg.sv
design/dpd_parser.sv
design/dpd_out_reg.sv
design/debug_packet_deframer_core.sv
bench/tb.sv
